// ===== rtl/rbep_pkg.sv =====
// Shared types and constants for the ray box exit point pipeline.
// No dependencies; every other file except rbep_if refers to it by scoped names.
`default_nettype none
package rbep_pkg;
    localparam int NumAxes  = 3;
    localparam int NumSlabs = 2 * NumAxes;
    localparam int NumRegs  = 2 * NumAxes;
    localparam int AddrW    = 5;
    localparam int DivSteps = 63;
    localparam logic [63:0] RatioMax = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word [NumRegs-1:0] bound;
    } t_box;

    typedef struct packed {
        t_word [NumAxes-1:0] start;
        t_word [NumAxes-1:0] dir;
    } t_ray;

    typedef struct packed {
        t_ray                       ray;
        logic [NumSlabs-1:0][32:0]  q;
        logic [NumSlabs-1:0][32:0]  p;
    } t_slab_in;

    typedef struct packed {
        logic        zero_p;
        logic        q_ge0;
        logic        p_neg;
        logic        neg;
        logic        sat;
        logic [31:0] rem;
        logic [31:0] mp;
        logic [30:0] dvd;
        logic [62:0] quot;
    } t_lane;

    typedef struct packed {
        t_ray                    ray;
        t_lane [NumSlabs-1:0]    lane;
    } t_div;

    typedef struct packed {
        logic        zero_p;
        logic        q_ge0;
        logic        p_neg;
        logic [63:0] r;
    } t_ratio;

    typedef struct packed {
        t_ray                    ray;
        t_ratio [NumSlabs-1:0]   s;
    } t_rat_stage;

    typedef struct packed {
        t_ray                    ray;
        t_ratio [NumSlabs-1:0]   s;
        logic                    ok;
        logic                    open_out;
        logic [63:0]             t_in;
        logic [63:0]             t_out;
    } t_clip;

    typedef struct packed {
        t_ray        ray;
        logic        hit;
        logic [63:0] t_out;
    } t_hit;

    typedef struct packed {
        logic                hit;
        t_word [NumAxes-1:0] pt;
    } t_res;
endpackage
`default_nettype wire

// ===== rtl/rbep_if.sv =====
// Ray and exit point channel interfaces with valid/ready handshake.
// Standalone; used by the top level ports.
`default_nettype none
interface rbep_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbep_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] exit_x;
    logic signed [31:0] exit_y;
    logic signed [31:0] exit_z;

    modport source (output valid, hit, exit_x, exit_y, exit_z, input ready);
    modport sink (input valid, hit, exit_x, exit_y, exit_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbep_regs.sv =====
// APB box bound registers.
// Depends on rbep_pkg.
`default_nettype none
module rbep_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rbep_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output rbep_pkg::t_box                 o_box
);
    rbep_pkg::t_box   r_box;
    rbep_pkg::t_box   n_box;
    rbep_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = rbep_pkg::t_reg_idx'(paddr[rbep_pkg::AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_box  = r_box;

    always_comb begin
        n_box  = r_box;
        prdata = '0;
        case (w_idx)
            rbep_pkg::REG_MIN_X, rbep_pkg::REG_MIN_Y, rbep_pkg::REG_MIN_Z,
            rbep_pkg::REG_MAX_X, rbep_pkg::REG_MAX_Y, rbep_pkg::REG_MAX_Z: begin
                prdata = r_box.bound[w_idx];
                if (w_wr) begin
                    n_box.bound[w_idx] = pwdata;
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else begin
            r_box <= n_box;
        end
    end

`ifndef SYNTHESIS
    a_wr_min_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && w_idx == rbep_pkg::REG_MIN_X) |=> r_box.bound[0] == $past(pwdata))
        else $error("min x write lost");
    a_wr_max_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && w_idx == rbep_pkg::REG_MAX_Z) |=> r_box.bound[5] == $past(pwdata))
        else $error("max z write lost");
    a_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_wr |=> $stable(r_box))
        else $error("bounds changed without write");
`endif
endmodule
`default_nettype wire

// ===== rtl/rbep_div.sv =====
// Slab distance setup and six-lane restoring divider, one quotient bit per stage.
// Depends on rbep_pkg.
`default_nettype none
module rbep_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire rbep_pkg::t_ray       i_ray,
    input  wire rbep_pkg::t_box       i_box,
    output logic                      o_valid,
    output rbep_pkg::t_rat_stage      o_rat
);
    localparam int Steps = rbep_pkg::DivSteps;

    rbep_pkg::t_slab_in   r_a, n_a;
    logic                 r_a_v;
    rbep_pkg::t_div       r_st [0:Steps];
    rbep_pkg::t_div       n_st [0:Steps];
    logic [Steps:0]       r_v;
    rbep_pkg::t_rat_stage r_n, n_n;
    logic                 r_n_v;

    function automatic rbep_pkg::t_lane step_lane(input rbep_pkg::t_lane l);
        rbep_pkg::t_lane o;
        logic [32:0]     t;
        logic            ge;
        o    = l;
        t    = {l.rem, l.dvd[30]};
        ge   = t >= {1'b0, l.mp};
        o.rem  = ge ? 32'(t - {1'b0, l.mp}) : t[31:0];
        o.dvd  = {l.dvd[29:0], 1'b0};
        o.quot = {l.quot[61:0], ge};
        return o;
    endfunction

    always_comb begin
        logic [32:0] s, lo, hi, d;
        n_a.ray = i_ray;
        for (int a = 0; a < rbep_pkg::NumAxes; a++) begin
            s  = {i_ray.start[a][31], i_ray.start[a]};
            d  = {i_ray.dir[a][31], i_ray.dir[a]};
            lo = {i_box.bound[a][31], i_box.bound[a]};
            hi = {i_box.bound[a+3][31], i_box.bound[a+3]};
            n_a.q[2*a]   = s - lo;
            n_a.p[2*a]   = -d;
            n_a.q[2*a+1] = hi - s;
            n_a.p[2*a+1] = d;
        end
    end

    always_comb begin
        logic [32:0] mq, mp;
        n_st[0].ray = r_a.ray;
        for (int k = 0; k < rbep_pkg::NumSlabs; k++) begin
            mq = r_a.q[k][32] ? 33'(-r_a.q[k]) : r_a.q[k];
            mp = r_a.p[k][32] ? 33'(-r_a.p[k]) : r_a.p[k];
            n_st[0].lane[k].zero_p = r_a.p[k] == '0;
            n_st[0].lane[k].q_ge0  = !r_a.q[k][32];
            n_st[0].lane[k].p_neg  = r_a.p[k][32];
            n_st[0].lane[k].neg    = r_a.q[k][32] ^ r_a.p[k][32];
            n_st[0].lane[k].sat    = {30'b0, mq} >= {mp[31:0], 31'b0};
            n_st[0].lane[k].rem    = {30'b0, mq[32:31]};
            n_st[0].lane[k].mp     = mp[31:0];
            n_st[0].lane[k].dvd    = mq[30:0];
            n_st[0].lane[k].quot   = '0;
        end
    end

    for (genvar g = 0; g < Steps; g++) begin : g_step
        always_comb begin
            n_st[g+1].ray = r_st[g].ray;
            for (int k = 0; k < rbep_pkg::NumSlabs; k++) begin
                n_st[g+1].lane[k] = step_lane(r_st[g].lane[k]);
            end
        end
    end

    always_comb begin
        logic [63:0] mag;
        n_n.ray = r_st[Steps].ray;
        for (int k = 0; k < rbep_pkg::NumSlabs; k++) begin
            mag = r_st[Steps].lane[k].sat ? rbep_pkg::RatioMax
                                          : {1'b0, r_st[Steps].lane[k].quot};
            n_n.s[k].zero_p = r_st[Steps].lane[k].zero_p;
            n_n.s[k].q_ge0  = r_st[Steps].lane[k].q_ge0;
            n_n.s[k].p_neg  = r_st[Steps].lane[k].p_neg;
            n_n.s[k].r      = r_st[Steps].lane[k].neg ? -mag : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_v   <= '0;
            r_n_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_v   <= {r_v[Steps-1:0], r_a_v};
            r_n_v <= r_v[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_n <= n_n;
        end
    end

    for (genvar g = 0; g <= Steps; g++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_valid = r_n_v;
    assign o_rat   = r_n;
endmodule
`default_nettype wire

// ===== rtl/rbep_clip.sv =====
// Six slab tests, one per stage, narrowing the entry and exit parameters.
// Depends on rbep_pkg.
`default_nettype none
module rbep_clip (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire rbep_pkg::t_rat_stage i_rat,
    output logic                      o_valid,
    output rbep_pkg::t_hit            o_hit
);
    localparam int N = rbep_pkg::NumSlabs;

    rbep_pkg::t_clip w_cur [0:N-1];
    rbep_pkg::t_clip n_st  [0:N-1];
    rbep_pkg::t_clip r_st  [0:N-1];
    logic [N-1:0]    r_v;

    function automatic rbep_pkg::t_clip slab(input rbep_pkg::t_clip c, input int k);
        rbep_pkg::t_clip o;
        rbep_pkg::t_ratio sl;
        o  = c;
        sl = c.s[k];
        if (c.ok) begin
            if (sl.zero_p) begin
                o.ok = sl.q_ge0;
            end else if (sl.p_neg) begin
                if (!c.open_out && $signed(sl.r) > $signed(c.t_out)) begin
                    o.ok = 1'b0;
                end else if ($signed(sl.r) > $signed(c.t_in)) begin
                    o.t_in = sl.r;
                end
            end else begin
                if ($signed(sl.r) < $signed(c.t_in)) begin
                    o.ok = 1'b0;
                end else if (c.open_out || $signed(sl.r) < $signed(c.t_out)) begin
                    o.t_out    = sl.r;
                    o.open_out = 1'b0;
                end
            end
        end
        return o;
    endfunction

    always_comb begin
        w_cur[0].ray      = i_rat.ray;
        w_cur[0].s        = i_rat.s;
        w_cur[0].ok       = 1'b1;
        w_cur[0].open_out = 1'b1;
        w_cur[0].t_in     = '0;
        w_cur[0].t_out    = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_slab
        if (k > 0) begin : g_link
            assign w_cur[k] = r_st[k-1];
        end
        assign n_st[k] = slab(w_cur[k], k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    assign o_valid     = r_v[N-1];
    assign o_hit.ray   = r_st[N-1].ray;
    assign o_hit.hit   = r_st[N-1].ok && !r_st[N-1].open_out;
    assign o_hit.t_out = r_st[N-1].t_out;
endmodule
`default_nettype wire

// ===== rtl/rbep_exit.sv =====
// Exit point arithmetic: multiply, align, sign and saturating add over four stages.
// Depends on rbep_pkg.
`default_nettype none
module rbep_exit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire rbep_pkg::t_hit  i_hit,
    output logic                 o_valid,
    output rbep_pkg::t_res       o_res
);
    localparam int A = rbep_pkg::NumAxes;

    logic                      r_m_hit, r_s_hit, r_o_hit;
    rbep_pkg::t_word [A-1:0]   r_m_st, r_s_st, r_o_st;
    logic [A-1:0]              r_m_neg, r_s_neg;
    logic [A-1:0][63:0]        r_ph, r_pl, n_ph, n_pl;
    logic [A-1:0][63:0]        r_mag, n_mag;
    logic [A-1:0][64:0]        r_off, n_off;
    rbep_pkg::t_res            r_res, n_res;
    logic [3:0]                r_v;

    always_comb begin
        logic [31:0] md;
        for (int a = 0; a < A; a++) begin
            md = i_hit.ray.dir[a][31] ? 32'(-i_hit.ray.dir[a]) : i_hit.ray.dir[a];
            n_ph[a] = i_hit.t_out[63:32] * md;
            n_pl[a] = i_hit.t_out[31:0] * md;
        end
    end

    always_comb begin
        for (int a = 0; a < A; a++) begin
            n_mag[a] = r_ph[a] + {32'b0, r_pl[a][63:32]};
        end
    end

    always_comb begin
        for (int a = 0; a < A; a++) begin
            n_off[a] = r_s_neg[a] ? 65'(-{1'b0, r_mag[a]}) : {1'b0, r_mag[a]};
        end
    end

    always_comb begin
        logic [65:0] sum;
        n_res.hit = r_o_hit;
        for (int a = 0; a < A; a++) begin
            sum = {{34{r_o_st[a][31]}}, r_o_st[a]} + {r_off[a][64], r_off[a]};
            if (!r_o_hit) begin
                n_res.pt[a] = '0;
            end else if (sum[65:31] == '0 || sum[65:31] == '1) begin
                n_res.pt[a] = sum[31:0];
            end else if (!sum[65]) begin
                n_res.pt[a] = 32'h7FFF_FFFF;
            end else begin
                n_res.pt[a] = 32'h8000_0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_hit <= i_hit.hit;
            r_m_st  <= i_hit.ray.start;
            for (int a = 0; a < A; a++) begin
                r_m_neg[a] <= i_hit.ray.dir[a][31];
            end
            r_ph    <= n_ph;
            r_pl    <= n_pl;
            r_s_hit <= r_m_hit;
            r_s_st  <= r_m_st;
            r_s_neg <= r_m_neg;
            r_mag   <= n_mag;
            r_o_hit <= r_s_hit;
            r_o_st  <= r_s_st;
            r_off   <= n_off;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_v[3];
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== rtl/ray_box_exit_point.sv =====
// Ray against axis-aligned box clipping; returns hit and exit point per ray.
// Depends on rbep_pkg, rbep_if, rbep_regs, rbep_div, rbep_clip, rbep_exit.
//
// One ray is taken every cycle while the pipeline is not stalled, and one result
// leaves per ray, in order. A ray passes 66 stages that form the six slab
// parameters (setup, divider entry, 63 bit-per-stage divider steps, sign and
// saturate), then six slab stages, four exit arithmetic stages and the output
// register. A two-entry output buffer keeps input flowing while a result waits;
// the whole pipeline stalls only when both entries are full. Box bounds must be
// written over APB only while idle; the block itself does not enforce this.
`default_nettype none
module ray_box_exit_point (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rbep_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    rbep_in_if.sink                         i_ray,
    rbep_out_if.source                      o_exit
);
    rbep_pkg::t_box       w_box;
    rbep_pkg::t_ray       w_ray;
    rbep_pkg::t_rat_stage w_rat;
    rbep_pkg::t_hit       w_hit;
    rbep_pkg::t_res       w_res;
    logic                 w_en, w_rat_v, w_hit_v, w_res_v;
    rbep_pkg::t_res       r_out, n_out, r_skid, n_skid;
    logic                 r_out_v, n_out_v, r_skid_v, n_skid_v;

    rbep_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_box(w_box)
    );

    assign w_ray.start[0] = i_ray.start_x;
    assign w_ray.start[1] = i_ray.start_y;
    assign w_ray.start[2] = i_ray.start_z;
    assign w_ray.dir[0]   = i_ray.dir_x;
    assign w_ray.dir[1]   = i_ray.dir_y;
    assign w_ray.dir[2]   = i_ray.dir_z;

    assign w_en        = !r_skid_v;
    assign i_ray.ready = w_en;

    rbep_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_ray.valid), .i_ray(w_ray),
        .i_box(w_box), .o_valid(w_rat_v), .o_rat(w_rat)
    );

    rbep_clip u_clip (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_rat_v), .i_rat(w_rat),
        .o_valid(w_hit_v), .o_hit(w_hit)
    );

    rbep_exit u_exit (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_hit_v), .i_hit(w_hit),
        .o_valid(w_res_v), .o_res(w_res)
    );

    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (!r_out_v || o_exit.ready) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out    = w_res;
                n_out_v  = w_res_v;
            end
        end else if (w_res_v && w_en) begin
            n_skid   = w_res;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_exit.valid  = r_out_v;
    assign o_exit.hit    = r_out.hit;
    assign o_exit.exit_x = r_out.pt[0];
    assign o_exit.exit_y = r_out.pt[1];
    assign o_exit.exit_z = r_out.pt[2];

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry without output entry");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_exit.ready))
        else $error("skid filled while output free");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.hit) |-> (r_out.pt[0] == '0 && r_out.pt[1] == '0
                                     && r_out.pt[2] == '0))
        else $error("miss with nonzero point");
`endif
endmodule
`default_nettype wire
